### hdl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros used by the checker file
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define JSM_IMPLY(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define JSM_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

### hdl/jsm_pkg.sv
// ---------------------------------------------------------------------------
// jsm_pkg
// Shared constants, types and phase codes of the JTAG scan master.
// ---------------------------------------------------------------------------
package jsm_pkg;

  localparam int SHIFT_WIDTH = 64;
  localparam int RESET_TICKS = 127;

  localparam int DATA_W = 64;
  localparam int LEN_W  = 7;
  localparam int CNT_W  = 8;
  localparam int IDX_W  = $clog2(SHIFT_WIDTH);

  typedef enum logic [3:0] {
    PH_INIT_RESET = 4'd0,
    PH_RESET_TAP  = 4'd1,
    PH_IDLE       = 4'd2,
    PH_SEL_DR1    = 4'd3,
    PH_SEL_IR     = 4'd4,
    PH_CAP_IR     = 4'd5,
    PH_SHIFT_IR   = 4'd6,
    PH_EXIT1_IR   = 4'd7,
    PH_UPD_IR     = 4'd8,
    PH_SEL_DR     = 4'd9,
    PH_CAP_DR     = 4'd10,
    PH_SHIFT_DR   = 4'd11,
    PH_EXIT1_DR   = 4'd12,
    PH_UPD_DR     = 4'd13
  } phase_t;

  // One tick as held in the queue, values already cut to the shift width.
  typedef struct packed {
    logic                   req;
    logic [LEN_W-1:0]       ir_length;
    logic [SHIFT_WIDTH-1:0] ir_value;
    logic [LEN_W-1:0]       dr_len;
    logic [SHIFT_WIDTH-1:0] dr_value;
    logic                   tdi_bit;
  } tick_t;

  // Queue head towards the scan engine.
  typedef struct packed {
    logic  valid;
    tick_t tick;
  } q_head_t;

endpackage

### hdl/jsm_front.sv
// ---------------------------------------------------------------------------
// jsm_front
// Input side: takes tick beats, trims payload to the shift width and holds
// them in a two-entry queue for the scan engine.
// ---------------------------------------------------------------------------
module jsm_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_req,
  input  logic [6:0]           in_ir_length,
  input  logic [63:0]          in_ir_value,
  input  logic [6:0]           in_dr_len,
  input  logic [63:0]          in_dr_value,
  input  logic                 in_tdi_bit,
  output jsm_pkg::q_head_t     head,
  input  logic                 pop
);

  jsm_pkg::tick_t slot_r [2];
  logic           wr_ptr_r, wr_ptr_nxt;
  logic           rd_ptr_r, rd_ptr_nxt;
  logic [1:0]     count_r, count_nxt;
  logic           push;
  logic           do_pop;
  jsm_pkg::tick_t tick_in;

  assign in_ready = (count_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign do_pop   = pop && (count_r != 2'd0);

  always_comb begin
    tick_in.req       = in_req;
    tick_in.ir_length = in_ir_length;
    tick_in.ir_value  = in_ir_value[jsm_pkg::SHIFT_WIDTH-1:0];
    tick_in.dr_len    = in_dr_len;
    tick_in.dr_value  = in_dr_value[jsm_pkg::SHIFT_WIDTH-1:0];
    tick_in.tdi_bit   = in_tdi_bit;
  end

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= tick_in;
    end
  end

  assign head.valid = (count_r != 2'd0);
  assign head.tick  = slot_r[rd_ptr_r];

endmodule

### hdl/jsm_engine.sv
// ---------------------------------------------------------------------------
// jsm_engine
// TAP walk and shift datapath: one queued tick per step, result held in an
// output register until taken.
// ---------------------------------------------------------------------------
module jsm_engine (
  input  logic                 clk,
  input  logic                 rst_n,
  input  jsm_pkg::q_head_t     head,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_trst_out,
  output logic                 out_tms_out,
  output logic                 out_tdo_out,
  output logic                 out_rsp_vld,
  output logic [63:0]          out_rsp_word
);

  localparam int SW  = jsm_pkg::SHIFT_WIDTH;
  localparam int LW  = jsm_pkg::LEN_W;
  localparam int IW  = jsm_pkg::IDX_W;
  localparam int CW  = jsm_pkg::CNT_W;

  jsm_pkg::phase_t phase_r, phase_nxt;

  logic          pend_v_r,     pend_v_nxt;
  logic [LW-1:0] pend_irlen_r, pend_irlen_nxt;
  logic [SW-1:0] pend_ir_r,    pend_ir_nxt;
  logic [LW-1:0] pend_drlen_r, pend_drlen_nxt;
  logic [SW-1:0] pend_dr_r,    pend_dr_nxt;
  logic [SW-1:0] instr_r,      instr_nxt;
  logic [CW-1:0] cdown_r,      cdown_nxt;
  logic [LW-1:0] bcnt_r,       bcnt_nxt;
  logic [SW-1:0] shift_r,      shift_nxt;
  logic [SW-1:0] resp_r,       resp_nxt;

  logic          o_valid_r;
  logic          o_trst_r, o_tms_r, o_tdo_r, o_rv_r;
  logic [SW-1:0] o_data_r;

  logic          step;
  logic          trst, tms, rflag;
  logic [SW-1:0] sh;
  logic [LW-1:0] dr_m1;
  logic [IW-1:0] idx;
  jsm_pkg::tick_t t;

  assign t    = head.tick;
  assign step = head.valid && (!o_valid_r || out_ready);
  assign pop  = step;

  assign dr_m1 = pend_drlen_r - LW'(1);

  always_comb begin
    if (pend_drlen_r == '0) begin
      idx = '0;
    end else if (dr_m1 > LW'(SW - 1)) begin
      idx = IW'(SW - 1);
    end else begin
      idx = dr_m1[IW-1:0];
    end
  end

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    unique case (phase_r)
      jsm_pkg::PH_INIT_RESET: begin
        if (cdown_r == '0) phase_nxt = jsm_pkg::PH_RESET_TAP;
      end
      jsm_pkg::PH_RESET_TAP: phase_nxt = jsm_pkg::PH_IDLE;
      jsm_pkg::PH_IDLE: begin
        if (pend_v_r) phase_nxt = jsm_pkg::PH_SEL_DR1;
      end
      jsm_pkg::PH_SEL_DR1: phase_nxt = jsm_pkg::PH_SEL_IR;
      jsm_pkg::PH_SEL_IR:  phase_nxt = jsm_pkg::PH_CAP_IR;
      jsm_pkg::PH_CAP_IR:  phase_nxt = jsm_pkg::PH_SHIFT_IR;
      jsm_pkg::PH_SHIFT_IR: begin
        if (bcnt_r <= LW'(1)) phase_nxt = jsm_pkg::PH_EXIT1_IR;
      end
      jsm_pkg::PH_EXIT1_IR: phase_nxt = jsm_pkg::PH_UPD_IR;
      jsm_pkg::PH_UPD_IR:   phase_nxt = jsm_pkg::PH_SEL_DR;
      jsm_pkg::PH_SEL_DR:   phase_nxt = jsm_pkg::PH_CAP_DR;
      jsm_pkg::PH_CAP_DR:   phase_nxt = jsm_pkg::PH_SHIFT_DR;
      jsm_pkg::PH_SHIFT_DR: begin
        if (bcnt_r <= LW'(1)) phase_nxt = jsm_pkg::PH_EXIT1_DR;
      end
      jsm_pkg::PH_EXIT1_DR: phase_nxt = jsm_pkg::PH_UPD_DR;
      jsm_pkg::PH_UPD_DR:   phase_nxt = jsm_pkg::PH_IDLE;
      default:              phase_nxt = jsm_pkg::PH_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    trst        = 1'b0;
    tms         = 1'b0;
    rflag       = 1'b0;
    sh          = shift_r;
    instr_nxt   = instr_r;
    cdown_nxt   = cdown_r;
    bcnt_nxt    = bcnt_r;
    resp_nxt    = resp_r;
    pend_v_nxt     = pend_v_r;
    pend_irlen_nxt = pend_irlen_r;
    pend_ir_nxt    = pend_ir_r;
    pend_drlen_nxt = pend_drlen_r;
    pend_dr_nxt    = pend_dr_r;

    if (t.req) begin
      pend_v_nxt     = 1'b1;
      pend_irlen_nxt = t.ir_length;
      pend_ir_nxt    = t.ir_value;
      pend_drlen_nxt = t.dr_len;
      pend_dr_nxt    = t.dr_value;
    end

    unique case (phase_r)
      jsm_pkg::PH_INIT_RESET: begin
        trst = 1'b1;
        tms  = 1'b1;
        if (cdown_r != '0) cdown_nxt = cdown_r - CW'(1);
      end
      jsm_pkg::PH_RESET_TAP: begin
        trst      = 1'b1;
        instr_nxt = '1;
      end
      jsm_pkg::PH_IDLE: begin
        resp_nxt = '0;
        if (pend_v_r) begin
          pend_v_nxt = 1'b0;
          tms        = 1'b1;
        end
      end
      jsm_pkg::PH_SEL_DR1: tms = 1'b1;
      jsm_pkg::PH_SEL_IR:  instr_nxt = pend_ir_r;
      jsm_pkg::PH_CAP_IR: begin
        sh       = instr_r;
        bcnt_nxt = pend_irlen_r;
      end
      jsm_pkg::PH_SHIFT_IR: begin
        if (bcnt_r <= LW'(1)) begin
          tms = 1'b1;
        end else begin
          sh       = shift_r >> 1;
          bcnt_nxt = bcnt_r - LW'(1);
        end
      end
      jsm_pkg::PH_EXIT1_IR: tms = 1'b1;
      jsm_pkg::PH_UPD_IR:   tms = 1'b1;
      jsm_pkg::PH_SEL_DR:   tms = 1'b0;
      jsm_pkg::PH_CAP_DR: begin
        sh       = pend_dr_r;
        bcnt_nxt = pend_drlen_r;
      end
      jsm_pkg::PH_SHIFT_DR: begin
        sh = shift_r >> 1;
        if (bcnt_r <= LW'(1)) begin
          tms = 1'b1;
        end else begin
          bcnt_nxt = bcnt_r - LW'(1);
        end
      end
      jsm_pkg::PH_EXIT1_DR: tms = 1'b1;
      jsm_pkg::PH_UPD_DR: begin
        rflag    = 1'b1;
        resp_nxt = shift_r;
      end
      default: tms = 1'b0;
    endcase

    shift_nxt      = sh;
    shift_nxt[idx] = t.tdi_bit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= jsm_pkg::PH_INIT_RESET;
      pend_v_r     <= 1'b0;
      pend_irlen_r <= '0;
      pend_ir_r    <= '0;
      pend_drlen_r <= '0;
      pend_dr_r    <= '0;
      instr_r      <= '1;
      cdown_r      <= CW'(jsm_pkg::RESET_TICKS);
      bcnt_r       <= '0;
      shift_r      <= '0;
      resp_r       <= '0;
    end else if (step) begin
      phase_r      <= phase_nxt;
      pend_v_r     <= pend_v_nxt;
      pend_irlen_r <= pend_irlen_nxt;
      pend_ir_r    <= pend_ir_nxt;
      pend_drlen_r <= pend_drlen_nxt;
      pend_dr_r    <= pend_dr_nxt;
      instr_r      <= instr_nxt;
      cdown_r      <= cdown_nxt;
      bcnt_r       <= bcnt_nxt;
      shift_r      <= shift_nxt;
      resp_r       <= resp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_valid_r <= 1'b0;
    end else if (step) begin
      o_valid_r <= 1'b1;
    end else if (out_ready) begin
      o_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      o_trst_r <= trst;
      o_tms_r  <= tms;
      o_tdo_r  <= shift_r[0];
      o_rv_r   <= rflag;
      o_data_r <= resp_nxt;
    end
  end

  assign out_valid    = o_valid_r;
  assign out_trst_out = o_trst_r;
  assign out_tms_out  = o_tms_r;
  assign out_tdo_out  = o_tdo_r;
  assign out_rsp_vld  = o_rv_r;
  assign out_rsp_word = jsm_pkg::DATA_W'(o_data_r);

endmodule

### hdl/jtag_scan_master_core.sv
// ---------------------------------------------------------------------------
// jtag_scan_master_core
// JTAG scan master stepped once per TCK tick.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): one beat per TCK tick, carrying an
//   optional scan request (in_req with IR/DR lengths and values) and
//   the TDI bit sampled from the target on that tick.
//   Result channel (out_valid/out_ready): exactly one beat per input beat,
//   in order, with TRST, TMS and TDO for the tick and the DR response.
//   out_rsp_vld marks the Update-DR tick; out_rsp_word then holds the
//   captured word.
// Timing: a taken beat is written to the input queue, and the engine
//   registers its result when it steps. One beat per cycle sustained while
//   out_ready is high, the engine stepping from the two-entry input queue.
// Reset: TMS high with TRST asserted for RESET_TICKS+1 ticks, then one more
//   TRST tick, then idle. The queue is empty after reset.
// Stall: while a result beat waits on out_ready low, it holds; the queue keeps
//   taking beats until both entries are full, then in_ready drops.
// ---------------------------------------------------------------------------
module jtag_scan_master_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_req,
  input  logic [6:0]  in_ir_length,
  input  logic [63:0] in_ir_value,
  input  logic [6:0]  in_dr_len,
  input  logic [63:0] in_dr_value,
  input  logic        in_tdi_bit,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_trst_out,
  output logic        out_tms_out,
  output logic        out_tdo_out,
  output logic        out_rsp_vld,
  output logic [63:0] out_rsp_word
);

  jsm_pkg::q_head_t head;
  logic             pop;

  jsm_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_req       (in_req),
    .in_ir_length (in_ir_length),
    .in_ir_value  (in_ir_value),
    .in_dr_len    (in_dr_len),
    .in_dr_value  (in_dr_value),
    .in_tdi_bit   (in_tdi_bit),
    .head         (head),
    .pop          (pop)
  );

  jsm_engine u_engine (
    .clk          (clk),
    .rst_n        (rst_n),
    .head         (head),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_trst_out (out_trst_out),
    .out_tms_out  (out_tms_out),
    .out_tdo_out  (out_tdo_out),
    .out_rsp_vld  (out_rsp_vld),
    .out_rsp_word (out_rsp_word)
  );

endmodule

### hdl/jsm_checker.sv
// ---------------------------------------------------------------------------
// jsm_checker
// Port-level checks on the scan master, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module jsm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_trst_out,
  input logic        out_tms_out,
  input logic        out_rsp_vld,
  input logic [63:0] out_rsp_word
);

  `JSM_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_rsp_word), "result beat dropped or changed while stalled")
  `JSM_IMPLY(a_upd_lines, out_valid && out_rsp_vld, !out_trst_out && !out_tms_out, "Update-DR beat with TMS or TRST high")
  `JSM_IMPLY(a_rst_no_resp, out_valid && out_trst_out, !out_rsp_vld && (out_rsp_word == 64'd0), "response during TAP reset")
  `JSM_NEXT(a_no_beat_from_air, !in_valid && !out_valid, !out_valid || in_ready, "result beat with a full queue and no input")

endmodule

bind jtag_scan_master_core jsm_checker u_jsm_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_trst_out (out_trst_out),
  .out_tms_out  (out_tms_out),
  .out_rsp_vld  (out_rsp_vld),
  .out_rsp_word (out_rsp_word)
);

### test/jtag_scan_master_core_tb.sv
// ---------------------------------------------------------------------------
// jtag_scan_master_core_tb
// Self-checking bench for the JTAG scan master core. Every TCK tick beat
// taken on the input channel is run through a cycle-true model of the TAP
// walk. The model predicts TRST, TMS, TDO and the DR response for that tick,
// and each beat on the result channel is checked against the oldest
// prediction. The run covers the reset phases, directed scans at the length
// and value extremes, requests arriving mid-scan and on the consuming tick,
// and then random scans with random TDI under random stalls on both channels.
// ---------------------------------------------------------------------------
module jtag_scan_master_core_tb;

  localparam int RANDOM_TICKS = 390;
  localparam int CYCLE_LIMIT  = 200000;

  typedef struct packed {
    logic        req;
    logic [6:0]  ir_len;
    logic [63:0] ir_val;
    logic [6:0]  dr_len;
    logic [63:0] dr_val;
    logic        tdi;
  } tck_beat_t;

  typedef struct packed {
    logic        trst;
    logic        tms;
    logic        tdo;
    logic        rsp_vld;
    logic [63:0] rsp_word;
  } pins_t;

  class tap_scoreboard;
    jsm_pkg::phase_t                 tap_phase;
    logic                            pend_valid;
    logic [6:0]                      pend_ir_len;
    logic [jsm_pkg::SHIFT_WIDTH-1:0] pend_ir_val;
    logic [6:0]                      pend_dr_len;
    logic [jsm_pkg::SHIFT_WIDTH-1:0] pend_dr_val;
    logic [jsm_pkg::SHIFT_WIDTH-1:0] instr_word;
    logic [jsm_pkg::CNT_W-1:0]       reset_count;
    logic [6:0]                      bit_count;
    logic [jsm_pkg::SHIFT_WIDTH-1:0] shift_word;
    logic [jsm_pkg::SHIFT_WIDTH-1:0] resp_word;
    pins_t                           expected_pins[$];
    int                              mismatches;
    int                              checked;

    function new();
      tap_phase   = jsm_pkg::PH_INIT_RESET;
      pend_valid  = 1'b0;
      pend_ir_len = '0;
      pend_ir_val = '0;
      pend_dr_len = '0;
      pend_dr_val = '0;
      instr_word  = '1;
      reset_count = jsm_pkg::CNT_W'(jsm_pkg::RESET_TICKS);
      bit_count   = '0;
      shift_word  = '0;
      resp_word   = '0;
      mismatches  = 0;
      checked     = 0;
    endfunction

    function bit scan_idle();
      return tap_phase == jsm_pkg::PH_IDLE && !pend_valid;
    endfunction

    // Steps the TAP walk by one tick and queues the pin levels it drives.
    function void predict_pins(tck_beat_t b);
      pins_t                           e;
      jsm_pkg::phase_t                 nxt;
      logic [jsm_pkg::SHIFT_WIDTH-1:0] sh;
      int                              pos;
      logic                            old_pv;
      logic [6:0]                      old_irl;
      logic [6:0]                      old_drl;
      logic [jsm_pkg::SHIFT_WIDTH-1:0] old_irv;
      logic [jsm_pkg::SHIFT_WIDTH-1:0] old_drv;
      e       = '0;
      nxt     = tap_phase;
      sh      = shift_word;
      old_pv  = pend_valid;
      old_irl = pend_ir_len;
      old_drl = pend_dr_len;
      old_irv = pend_ir_val;
      old_drv = pend_dr_val;
      pos = (old_drl == 0) ? 0 : int'(old_drl) - 1;
      if (pos > jsm_pkg::SHIFT_WIDTH - 1) pos = jsm_pkg::SHIFT_WIDTH - 1;
      if (b.req) begin
        pend_valid  = 1'b1;
        pend_ir_len = b.ir_len;
        pend_ir_val = b.ir_val;
        pend_dr_len = b.dr_len;
        pend_dr_val = b.dr_val;
      end
      case (tap_phase)
        jsm_pkg::PH_INIT_RESET: begin
          e.trst = 1'b1;
          e.tms  = 1'b1;
          if (reset_count != 0) reset_count = reset_count - 1'b1;
          else nxt = jsm_pkg::PH_RESET_TAP;
        end
        jsm_pkg::PH_RESET_TAP: begin
          e.trst     = 1'b1;
          instr_word = '1;
          nxt        = jsm_pkg::PH_IDLE;
        end
        jsm_pkg::PH_IDLE: begin
          resp_word = '0;
          if (old_pv) begin
            pend_valid = 1'b0;
            e.tms      = 1'b1;
            nxt        = jsm_pkg::PH_SEL_DR1;
          end
        end
        jsm_pkg::PH_SEL_DR1: begin
          e.tms = 1'b1;
          nxt   = jsm_pkg::PH_SEL_IR;
        end
        jsm_pkg::PH_SEL_IR: begin
          instr_word = old_irv;
          nxt        = jsm_pkg::PH_CAP_IR;
        end
        jsm_pkg::PH_CAP_IR: begin
          sh        = instr_word;
          bit_count = old_irl;
          nxt       = jsm_pkg::PH_SHIFT_IR;
        end
        jsm_pkg::PH_SHIFT_IR: begin
          if (bit_count <= 1) begin
            e.tms = 1'b1;
            nxt   = jsm_pkg::PH_EXIT1_IR;
          end else begin
            sh        = shift_word >> 1;
            bit_count = bit_count - 1'b1;
          end
        end
        jsm_pkg::PH_EXIT1_IR: begin
          e.tms = 1'b1;
          nxt   = jsm_pkg::PH_UPD_IR;
        end
        jsm_pkg::PH_UPD_IR: begin
          e.tms = 1'b1;
          nxt   = jsm_pkg::PH_SEL_DR;
        end
        jsm_pkg::PH_SEL_DR: begin
          nxt = jsm_pkg::PH_CAP_DR;
        end
        jsm_pkg::PH_CAP_DR: begin
          sh        = old_drv;
          bit_count = old_drl;
          nxt       = jsm_pkg::PH_SHIFT_DR;
        end
        jsm_pkg::PH_SHIFT_DR: begin
          sh = shift_word >> 1;
          if (bit_count <= 1) begin
            e.tms = 1'b1;
            nxt   = jsm_pkg::PH_EXIT1_DR;
          end else begin
            bit_count = bit_count - 1'b1;
          end
        end
        jsm_pkg::PH_EXIT1_DR: begin
          e.tms = 1'b1;
          nxt   = jsm_pkg::PH_UPD_DR;
        end
        jsm_pkg::PH_UPD_DR: begin
          e.rsp_vld = 1'b1;
          resp_word = shift_word;
          nxt       = jsm_pkg::PH_IDLE;
        end
        default: begin
          nxt = jsm_pkg::PH_IDLE;
        end
      endcase
      e.tdo      = shift_word[0];
      sh[pos]    = b.tdi;
      shift_word = sh;
      tap_phase  = nxt;
      e.rsp_word = resp_word;
      expected_pins.push_back(e);
    endfunction

    function void check_pins(pins_t act);
      pins_t e;
      checked++;
      if (expected_pins.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result beat %0d: none expected (trst %b tms %b tdo %b resp %b %h)",
                   checked, act.trst, act.tms, act.tdo, act.rsp_vld, act.rsp_word);
        return;
      end
      e = expected_pins.pop_front();
      if (act.trst !== e.trst || act.tms !== e.tms || act.tdo !== e.tdo ||
          act.rsp_vld !== e.rsp_vld || act.rsp_word !== e.rsp_word) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"result beat %0d: exp trst %b tms %b tdo %b resp %b %h",
                    " / got trst %b tms %b tdo %b resp %b %h"},
                   checked, e.trst, e.tms, e.tdo, e.rsp_vld, e.rsp_word,
                   act.trst, act.tms, act.tdo, act.rsp_vld, act.rsp_word);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_req = 1'b0;
  logic [6:0]  in_ir_length = '0;
  logic [63:0] in_ir_value = '0;
  logic [6:0]  in_dr_len = '0;
  logic [63:0] in_dr_value = '0;
  logic        in_tdi_bit = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_trst_out;
  logic        out_tms_out;
  logic        out_tdo_out;
  logic        out_rsp_vld;
  logic [63:0] out_rsp_word;

  tap_scoreboard sb = new();
  bit            calm = 1'b0;
  int            cycles = 0;

  jtag_scan_master_core u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_req       (in_req),
    .in_ir_length (in_ir_length),
    .in_ir_value  (in_ir_value),
    .in_dr_len    (in_dr_len),
    .in_dr_value  (in_dr_value),
    .in_tdi_bit   (in_tdi_bit),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_trst_out (out_trst_out),
    .out_tms_out  (out_tms_out),
    .out_tdo_out  (out_tdo_out),
    .out_rsp_vld  (out_rsp_vld),
    .out_rsp_word (out_rsp_word)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_pins('{out_trst_out, out_tms_out, out_tdo_out, out_rsp_vld, out_rsp_word});
    out_ready <= calm || ($urandom_range(99) >= 11);
  end

  function automatic logic [63:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [6:0] rand_len();
    int r;
    r = $urandom_range(99);
    if (r < 70) return 7'($urandom_range(8));
    if (r < 92) return 7'($urandom_range(40));
    if (r < 97) return 7'($urandom_range(64, 41));
    return 7'd64;
  endfunction

  function automatic tck_beat_t filler_beat();
    return '{1'b0, 7'($urandom), rand_word(), 7'($urandom), rand_word(), 1'($urandom)};
  endfunction

  function automatic tck_beat_t req_beat(logic [6:0] irl, logic [63:0] irv,
                                         logic [6:0] drl, logic [63:0] drv);
    return '{1'b1, irl, irv, drl, drv, 1'($urandom)};
  endfunction

  // Offers one tick beat and waits for it to be taken.
  task automatic send_tick(tck_beat_t b);
    if (!calm && $urandom_range(99) < 11) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_req       <= b.req;
    in_ir_length <= b.ir_len;
    in_ir_value  <= b.ir_val;
    in_dr_len    <= b.dr_len;
    in_dr_value  <= b.dr_val;
    in_tdi_bit   <= b.tdi;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.predict_pins(b);
  endtask

  task automatic finish_scans();
    while (!sb.scan_idle()) send_tick(filler_beat());
  endtask

  task automatic run_scan(logic [6:0] irl, logic [63:0] irv,
                          logic [6:0] drl, logic [63:0] drv);
    send_tick(req_beat(irl, irv, drl, drv));
    finish_scans();
  endtask

  initial begin
    tck_beat_t b;
    int        n;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset phases, with one request landing in the middle of them
    n = 0;
    while (sb.tap_phase != jsm_pkg::PH_IDLE) begin
      if (n == 50) send_tick(req_beat(7'd3, rand_word(), 7'd4, rand_word()));
      else send_tick(filler_beat());
      n++;
    end
    finish_scans();

    run_scan(7'd0, '1, 7'd0, '0);
    run_scan(7'd1, '0, 7'd1, '1);
    run_scan(7'd2, rand_word(), 7'd2, rand_word());
    run_scan(7'd64, '1, 7'd64, '0);
    run_scan(7'd64, '0, 7'd64, '1);
    run_scan(7'd5, rand_word(), 7'd100, rand_word());

    // new request arriving in the middle of a scan
    send_tick(req_beat(7'd10, rand_word(), 7'd12, rand_word()));
    repeat (6) send_tick(filler_beat());
    send_tick(req_beat(7'd3, rand_word(), 7'd5, rand_word()));
    finish_scans();

    // second request on the tick that consumes the first
    send_tick(req_beat(7'd4, rand_word(), 7'd6, rand_word()));
    send_tick(req_beat(7'd9, rand_word(), 7'd3, rand_word()));
    finish_scans();

    for (int i = 0; i < RANDOM_TICKS; i++) begin
      calm = (i >= 100 && i < 250);
      if (i == 300) begin
        in_valid <= 1'b0;
        while (sb.expected_pins.size() != 0) @(posedge clk);
      end
      b = filler_beat();
      if (sb.scan_idle()) begin
        if ($urandom_range(99) < 88) b = req_beat(rand_len(), rand_word(), rand_len(), rand_word());
      end else if ($urandom_range(99) < 3) begin
        b = req_beat(rand_len(), rand_word(), rand_len(), rand_word());
      end
      send_tick(b);
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    while (sb.expected_pins.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0 && sb.expected_pins.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+hdl
hdl/jsm_pkg.sv
hdl/jsm_front.sv
hdl/jsm_engine.sv
hdl/jtag_scan_master_core.sv
hdl/jsm_checker.sv
test/jtag_scan_master_core_tb.sv
